// ===== rtl/core/tteng_pkg.sv =====
package tteng_pkg;

  localparam logic [1:0] ACT_GLYPH  = 2'd0;
  localparam logic [1:0] ACT_FILL   = 2'd1;
  localparam logic [1:0] ACT_SCROLL = 2'd2;
  localparam logic [1:0] ACT_CURSOR = 2'd3;

  localparam logic [1:0] ESC_NONE = 2'd0;
  localparam logic [1:0] ESC_SEEN = 2'd1;
  localparam logic [1:0] ESC_CSI  = 2'd2;

  localparam logic REG_COLUMNS = 1'b0;
  localparam logic REG_ROWS    = 1'b1;

  localparam logic [7:0] COLUMNS_RESET = 8'd80;
  localparam logic [7:0] ROWS_RESET    = 8'd25;

  localparam logic [15:0] CH_BS  = 16'h0008;
  localparam logic [15:0] CH_HT  = 16'h0009;
  localparam logic [15:0] CH_LF  = 16'h000A;
  localparam logic [15:0] CH_FF  = 16'h000C;
  localparam logic [15:0] CH_CR  = 16'h000D;
  localparam logic [15:0] CH_BEL = 16'h0007;
  localparam logic [15:0] CH_ESC = 16'h001B;

  localparam logic [13:0] PARAM_MAX = 14'd9999;

  localparam logic [3:0] FG_RESET = 4'd15;
  localparam logic [3:0] BG_RESET = 4'd0;

  typedef struct packed {
    logic [1:0]  utf8_left;
    logic [15:0] code_acc;
    logic [1:0]  esc_mode;
    logic [1:0]  param_index;
    logic [13:0] param_a;
    logic        param_a_given;
    logic [13:0] param_b;
    logic        param_b_given;
    logic [7:0]  cur_row;
    logic [7:0]  cur_col;
    logic [3:0]  fg;
    logic [3:0]  bg;
  } term_state_t;

  // For a cursor record, line and first_col carry the new row and column.
  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] glyph;
    logic [7:0]  line;
    logic [7:0]  first_col;
    logic [7:0]  last_col;
    logic [3:0]  fore;
    logic [3:0]  back;
  } rec_t;

  function automatic logic [3:0] bright_colour(input logic [2:0] idx);
    logic [3:0] r;
    begin
      case (idx)
        3'd0: r = 4'd8;
        3'd1: r = 4'd12;
        3'd2: r = 4'd10;
        3'd3: r = 4'd14;
        3'd4: r = 4'd9;
        3'd5: r = 4'd13;
        3'd6: r = 4'd11;
        default: r = 4'd15;
      endcase
      return r;
    end
  endfunction

  // v - n, floored at zero
  function automatic logic [7:0] sub_floor(input logic [7:0] v, input logic [13:0] n);
    logic [14:0] d;
    begin
      d = {7'd0, v} - {1'b0, n};
      return ({1'b0, n} > {7'd0, v}) ? 8'd0 : d[7:0];
    end
  endfunction

  // v + n, capped at lim
  function automatic logic [7:0] add_cap(input logic [7:0] v, input logic [13:0] n,
                                         input logic [7:0] lim);
    logic [14:0] s;
    begin
      s = {7'd0, v} + {1'b0, n};
      return (s > {7'd0, lim}) ? lim : s[7:0];
    end
  endfunction

  // n - 1 clamped to 0..lim
  function automatic logic [7:0] pos_clamp(input logic [13:0] n, input logic [7:0] lim);
    logic [13:0] m;
    begin
      m = n - 14'd1;
      if (n == 14'd0) return 8'd0;
      return (m > {6'd0, lim}) ? lim : m[7:0];
    end
  endfunction

endpackage

// ===== rtl/core/text_terminal_byte_engine.sv =====
// A byte waits in the input register until the result buffer is free; its first result
// word is offered on m_tvalid in the cycle after it is decoded.
// Throughput: one byte per cycle while m_tready is high and each byte yields at most one
// word; up to four words hold the next byte back while they drain, one per ready cycle.
// Reset (rst, synchronous): terminal state to home cursor, white on black,
// columns 80, rows 25, no escape or UTF-8 sequence pending, both buffers empty.
module text_terminal_byte_engine #(
  parameter int TAB_WIDTH = 8
) (
  input  logic        clk,
  input  logic        rst,
  // byte stream in
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] byte_in
  // result words out
  output logic        m_tvalid,
  input  logic        m_tready,
  // [1:0] action, [17:2] glyph, [25:18] line, [33:26] first_col, [41:34] last_col,
  // [45:42] fore, [49:46] back, [65:50] cursor_pos, [71:66] zero
  output logic [71:0] m_tdata,
  output logic        m_tlast,   // final word caused by this byte
  // register writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);
  import tteng_pkg::*;

  logic [7:0]  columns, rows;
  term_state_t st, st_next;

  // input register
  logic        in_valid;
  logic [7:0]  in_byte;

  // result buffer: up to four words from one byte, drained in order
  rec_t [3:0]  buf_rec, new_rec;
  logic [2:0]  left, new_cnt;
  logic [1:0]  ptr;

  logic        proc_fire, drain, buf_free;
  rec_t        head;
  logic [7:0]  ceff;
  logic [15:0] pos;

  tteng_step #(.TAB_WIDTH(TAB_WIDTH)) u_step (
    .st_cur  (st),
    .byte_in (in_byte),
    .columns (columns),
    .rows    (rows),
    .st_next (st_next),
    .recs    (new_rec),
    .rec_cnt (new_cnt)
  );

  assign cfg_ready = 1'b1;

  // The buffer takes a new byte's words once its last word leaves.
  assign m_tvalid  = (left != 3'd0);
  assign drain     = m_tvalid && m_tready;
  assign buf_free  = (left == 3'd0) || (left == 3'd1 && m_tready);
  assign proc_fire = in_valid && buf_free;
  assign s_tready  = !in_valid || proc_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      columns <= COLUMNS_RESET;
      rows    <= ROWS_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_COLUMNS: columns <= cfg_data;
        REG_ROWS:    rows    <= cfg_data;
        default: ;
      endcase
    end
  end

  // hold the byte until the decoder can take it
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (proc_fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) in_byte <= s_tdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '{utf8_left: 2'd0, code_acc: 16'd0, esc_mode: ESC_NONE, param_index: 2'd0,
              param_a: 14'd0, param_a_given: 1'b0, param_b: 14'd0, param_b_given: 1'b0,
              cur_row: 8'd0, cur_col: 8'd0, fg: FG_RESET, bg: BG_RESET};
      left <= 3'd0;
      ptr  <= 2'd0;
    end else if (proc_fire) begin
      st   <= st_next;
      left <= new_cnt;
      ptr  <= 2'd0;
    end else if (drain) begin
      left <= left - 3'd1;
      ptr  <= ptr + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_fire) buf_rec <= new_rec;
  end

  // Cursor words carry row and column; fold them into the linear position here.
  assign head = buf_rec[ptr];
  assign ceff = (columns == 8'd0) ? 8'd1 : columns;
  assign pos  = 16'(head.line) * 16'(ceff) + 16'(head.first_col);

  always_comb begin
    m_tdata = '0;
    m_tdata[1:0] = head.action;
    if (head.action == ACT_CURSOR) begin
      m_tdata[65:50] = pos;
    end else begin
      m_tdata[17:2]  = head.glyph;
      m_tdata[25:18] = head.line;
      m_tdata[33:26] = head.first_col;
      m_tdata[41:34] = head.last_col;
      m_tdata[45:42] = head.fore;
      m_tdata[49:46] = head.back;
    end
  end

  assign m_tlast = (left == 3'd1);

`ifndef SYNTH
  a_left_range: assert property (@(posedge clk) disable iff (rst) left <= 3'd4)
    else $error("result buffer count out of range");
  a_load_restarts: assert property (@(posedge clk) disable iff (rst)
    proc_fire |=> (ptr == 2'd0))
    else $error("buffer pointer not rewound on load");
  a_cursor_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && head.action == ACT_CURSOR) |-> m_tlast)
    else $error("cursor word not last of its byte");
  a_esc_code: assert property (@(posedge clk) disable iff (rst)
    st.esc_mode != 2'd3)
    else $error("escape mode reached unused code");
`endif

endmodule

// ===== rtl/core/tteng_step.sv =====
module tteng_step #(
  parameter int TAB_WIDTH = 8
) (
  input  tteng_pkg::term_state_t        st_cur,
  input  logic [7:0]                    byte_in,
  input  logic [7:0]                    columns,
  input  logic [7:0]                    rows,
  output tteng_pkg::term_state_t        st_next,
  output tteng_pkg::rec_t [3:0]         recs,
  output logic [2:0]                    rec_cnt
);
  import tteng_pkg::*;

  localparam int RECIP = (65536 + TAB_WIDTH - 1) / TAB_WIDTH;
  localparam logic [16:0] RECIP_V = 17'(RECIP);
  localparam logic [11:0] TAB_V   = 12'(TAB_WIDTH);

  logic [7:0]  ceff, reff, cl, rl;
  logic [24:0] tab_prod;
  logic [11:0] tab_next;

  assign ceff = (columns == 8'd0) ? 8'd1 : columns;
  assign reff = (rows == 8'd0) ? 8'd1 : rows;
  assign cl   = ceff - 8'd1;
  assign rl   = reff - 8'd1;

  // next tab stop: floor(col / TAB) by reciprocal, exact for 8-bit columns
  assign tab_prod = 25'(st_cur.cur_col) * 25'(RECIP_V);
  assign tab_next = (12'(tab_prod[23:16]) + 12'd1) * TAB_V;

  always_comb begin
    logic        pend;
    logic [15:0] cp;
    logic [15:0] acc;
    logic [13:0] n1, n2, sel, d;
    logic [16:0] dec;
    logic [8:0]  r9, c9;
    logic [7:0]  r8, c8;
    logic        fin;
    logic [2:0]  n;
    rec_t        blank;

    st_next = st_cur;
    blank   = '0;
    recs    = '{default: '0};
    n       = 3'd0;
    pend    = 1'b0;
    cp      = 16'd0;
    acc     = {st_cur.code_acc[9:0], byte_in[5:0]};
    n1      = st_cur.param_a_given ? st_cur.param_a : 14'd1;
    n2      = st_cur.param_b_given ? st_cur.param_b : 14'd1;
    sel     = st_cur.param_a_given ? st_cur.param_a : 14'd0;
    d       = '0;
    dec     = '0;
    r9      = '0;
    c9      = '0;
    r8      = st_cur.cur_row;
    c8      = st_cur.cur_col;
    fin     = 1'b1;

    // UTF-8 front end
    if (st_cur.utf8_left != 2'd0) begin
      if (byte_in[7:6] == 2'b10) begin
        st_next.code_acc  = acc;
        st_next.utf8_left = st_cur.utf8_left - 2'd1;
        pend = (st_cur.utf8_left != 2'd1);
        cp   = acc;
      end else begin
        st_next.utf8_left = 2'd0;
        cp = 16'd0;
      end
    end else if (byte_in[7:3] == 5'b11110) begin
      st_next.utf8_left = 2'd3;
      st_next.code_acc  = {13'd0, byte_in[2:0]};
      pend = 1'b1;
    end else if (byte_in[7:4] == 4'b1110) begin
      st_next.utf8_left = 2'd2;
      st_next.code_acc  = {12'd0, byte_in[3:0]};
      pend = 1'b1;
    end else if (byte_in[7:5] == 3'b110) begin
      st_next.utf8_left = 2'd1;
      st_next.code_acc  = {11'd0, byte_in[4:0]};
      pend = 1'b1;
    end else begin
      cp = {9'd0, byte_in[6:0]};
    end

    if (!pend) begin
      if (st_cur.esc_mode == ESC_SEEN) begin
        if (cp == 16'h005B) begin
          st_next.esc_mode = ESC_CSI;
        end else begin
          fin = 1'b1;
          st_next.esc_mode = ESC_NONE;
          st_next.param_index = '0;
          st_next.param_a = '0;
          st_next.param_a_given = 1'b0;
          st_next.param_b = '0;
          st_next.param_b_given = 1'b0;
        end
      end else if (st_cur.esc_mode != ESC_NONE) begin
        if (st_cur.esc_mode == ESC_CSI && cp >= 16'h0030 && cp <= 16'h0039) begin
          fin = 1'b0;
          d = {10'd0, cp[3:0]};
          if (st_cur.param_index == 2'd0) begin
            dec = st_cur.param_a_given ?
                  ({st_cur.param_a, 3'd0} + {2'd0, st_cur.param_a, 1'b0} + 17'(d)) : 17'(d);
            st_next.param_a = (dec > 17'(PARAM_MAX)) ? PARAM_MAX : dec[13:0];
            st_next.param_a_given = 1'b1;
          end else if (st_cur.param_index == 2'd1) begin
            dec = st_cur.param_b_given ?
                  ({st_cur.param_b, 3'd0} + {2'd0, st_cur.param_b, 1'b0} + 17'(d)) : 17'(d);
            st_next.param_b = (dec > 17'(PARAM_MAX)) ? PARAM_MAX : dec[13:0];
            st_next.param_b_given = 1'b1;
          end
        end else if (st_cur.esc_mode == ESC_CSI && cp == 16'h003B) begin
          fin = 1'b0;
          if (st_cur.param_index < 2'd2) st_next.param_index = st_cur.param_index + 2'd1;
        end else if (st_cur.esc_mode == ESC_CSI) begin
          case (cp)
            16'h0041: r8 = sub_floor(st_cur.cur_row, n1);
            16'h0042: r8 = add_cap(st_cur.cur_row, n1, rl);
            16'h0043: c8 = add_cap(st_cur.cur_col, n1, cl);
            16'h0044: c8 = sub_floor(st_cur.cur_col, n1);
            16'h0045: begin
              r8 = add_cap(st_cur.cur_row, n1, rl);
              c8 = 8'd0;
            end
            16'h0046: begin
              r8 = sub_floor(st_cur.cur_row, n1);
              c8 = 8'd0;
            end
            16'h0047: c8 = pos_clamp(n1, cl);
            16'h0048: begin
              r8 = pos_clamp(n1, rl);
              c8 = pos_clamp(n2, cl);
            end
            16'h004B: begin
              blank.action = ACT_FILL;
              blank.line   = st_cur.cur_row;
              blank.fore   = st_cur.fg;
              blank.back   = st_cur.bg;
              if (sel == 14'd0 && st_cur.cur_col <= cl) begin
                blank.first_col = st_cur.cur_col;
                blank.last_col  = cl;
                recs[0] = blank;
                n = 3'd1;
              end else if (sel == 14'd1) begin
                blank.last_col = (st_cur.cur_col > cl) ? cl : st_cur.cur_col;
                recs[0] = blank;
                n = 3'd1;
              end else if (sel == 14'd2) begin
                blank.last_col = cl;
                recs[0] = blank;
                n = 3'd1;
              end
            end
            16'h006D: begin
              if (sel == 14'd0) begin
                st_next.fg = FG_RESET;
                st_next.bg = BG_RESET;
              end else if (sel >= 14'd30 && sel <= 14'd37) begin
                st_next.fg = bright_colour(3'(sel - 14'd30));
              end else if (sel >= 14'd40 && sel <= 14'd47) begin
                st_next.bg = bright_colour(3'(sel - 14'd40));
              end
            end
            default: ;
          endcase
        end
        if (fin) begin
          st_next.cur_row = r8;
          st_next.cur_col = c8;
          st_next.esc_mode = ESC_NONE;
          st_next.param_index = '0;
          st_next.param_a = '0;
          st_next.param_a_given = 1'b0;
          st_next.param_b = '0;
          st_next.param_b_given = 1'b0;
        end
      end else begin
        r9 = {1'b0, st_cur.cur_row};
        c9 = {1'b0, st_cur.cur_col};
        case (cp)
          CH_BEL: ;
          CH_BS:  if (c9 != 9'd0) c9 = c9 - 9'd1;
          CH_HT:  c9 = tab_next[8:0];
          CH_LF: begin
            c9 = 9'd0;
            r9 = r9 + 9'd1;
          end
          CH_FF:  r9 = r9 + 9'd1;
          CH_CR:  c9 = 9'd0;
          CH_ESC: st_next.esc_mode = ESC_SEEN;
          default: begin
            blank.action    = ACT_GLYPH;
            blank.glyph     = cp;
            blank.line      = st_cur.cur_row;
            blank.first_col = st_cur.cur_col;
            blank.fore      = st_cur.fg;
            blank.back      = st_cur.bg;
            recs[n[1:0]] = blank;
            n  = n + 3'd1;
            c9 = c9 + 9'd1;
          end
        endcase
        if (c9 >= {1'b0, ceff}) begin
          c9 = 9'd0;
          r9 = r9 + 9'd1;
        end
        if (r9 >= {1'b0, reff}) begin
          blank = '0;
          blank.action = ACT_SCROLL;
          recs[n[1:0]] = blank;
          n = n + 3'd1;
          blank.action   = ACT_FILL;
          blank.line     = rl;
          blank.last_col = cl;
          blank.fore     = st_cur.fg;
          blank.back     = st_cur.bg;
          recs[n[1:0]] = blank;
          n  = n + 3'd1;
          c9 = 9'd0;
          r9 = {1'b0, rl};
        end
        st_next.cur_row = r9[7:0];
        st_next.cur_col = c9[7:0];
        blank = '0;
        blank.action    = ACT_CURSOR;
        blank.line      = r9[7:0];
        blank.first_col = c9[7:0];
        recs[n[1:0]] = blank;
        n = n + 3'd1;
      end
    end
    rec_cnt = n;
  end

endmodule
